>>> rtl/pwt_pkg.sv
// shared constants and controller/datapath interface types for the priority scheduler
`default_nettype none
package pwt_pkg;

   localparam int MAX_JOBS  = 64;
   localparam int IDX_W     = $clog2(MAX_JOBS);
   localparam int CNT_W     = $clog2(MAX_JOBS + 1);
   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;
   localparam int CLOCK_W   = 22;
   localparam int SUM_W     = 28;
   localparam int COUNT_W   = 7;
   localparam int INDEX_W   = 6;
   localparam int ENTRY_W   = ARR_W + BURST_W + PRIO_W;

   typedef struct packed {
      logic load;
      logic start;
      logic scan_init;
      logic scan_run;
      logic fetch;
      logic commit;
      logic finish;
   } pwt_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic last_done;
   } pwt_sts_type;

endpackage
`default_nettype wire

>>> rtl/pwt_ctrl.sv
// controller state machine for the priority scheduler
`default_nettype none
module pwt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last_job,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire pwt_pkg::pwt_sts_type sts,
   output pwt_pkg::pwt_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_OUTPUT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       req_accept;
   logic       rsp_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUTPUT);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.load      = req_accept;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_last_job) begin
               cmd.start     = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (rsp_accept) begin
               if (sts.last_done) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/pwt_dp.sv
// datapath for the priority scheduler: job memory, minimum scan and wait accumulation
`default_nettype none
module pwt_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pwt_pkg::pwt_cmd_type          cmd,
   output pwt_pkg::pwt_sts_type               sts,
   input  wire logic [pwt_pkg::ARR_W-1:0]     req_arrival,
   input  wire logic [pwt_pkg::BURST_W-1:0]   req_burst,
   input  wire logic [pwt_pkg::PRIO_W-1:0]    req_prio,
   output logic [pwt_pkg::INDEX_W-1:0]        rsp_job_index,
   output logic [pwt_pkg::ARR_W-1:0]          rsp_job_arrival,
   output logic [pwt_pkg::BURST_W-1:0]        rsp_job_burst,
   output logic [pwt_pkg::PRIO_W-1:0]         rsp_job_prio,
   output logic [pwt_pkg::CLOCK_W-1:0]        rsp_wait_time,
   output logic [pwt_pkg::SUM_W-1:0]          rsp_total_wait,
   output logic [pwt_pkg::COUNT_W-1:0]        rsp_job_count,
   output logic                               rsp_last_result
);

   logic [pwt_pkg::ENTRY_W-1:0] mem_ff [pwt_pkg::MAX_JOBS];
   logic [pwt_pkg::ENTRY_W-1:0] rdata_ff;
   logic [pwt_pkg::IDX_W-1:0]   raddr;

   logic [pwt_pkg::CNT_W-1:0]    count_ff;
   logic [pwt_pkg::MAX_JOBS-1:0] served_ff;
   logic [pwt_pkg::CNT_W-1:0]    scan_addr_ff;
   logic                         rd_valid_ff;
   logic [pwt_pkg::IDX_W-1:0]    rd_idx_ff;
   logic                         found_ff;
   logic [pwt_pkg::IDX_W-1:0]    best_ff;
   logic [pwt_pkg::PRIO_W-1:0]   best_prio_ff;
   logic [pwt_pkg::CLOCK_W-1:0]  clock_ff;
   logic [pwt_pkg::SUM_W-1:0]    sum_ff;
   logic [pwt_pkg::CNT_W-1:0]    done_ff;

   logic [pwt_pkg::INDEX_W-1:0]  out_index_ff;
   logic [pwt_pkg::ARR_W-1:0]    out_arrival_ff;
   logic [pwt_pkg::BURST_W-1:0]  out_burst_ff;
   logic [pwt_pkg::PRIO_W-1:0]   out_prio_ff;
   logic [pwt_pkg::CLOCK_W-1:0]  out_wait_ff;
   logic [pwt_pkg::SUM_W-1:0]    out_sum_ff;
   logic                         out_last_ff;

   logic                         scan_issue;
   logic                         take_best;
   logic [pwt_pkg::ARR_W-1:0]    rd_arrival;
   logic [pwt_pkg::BURST_W-1:0]  rd_burst;
   logic [pwt_pkg::PRIO_W-1:0]   rd_prio;
   logic [pwt_pkg::CLOCK_W-1:0]  arr_ext;
   logic [pwt_pkg::CLOCK_W-1:0]  wait_in;
   logic [pwt_pkg::SUM_W-1:0]    sum_in;
   logic [pwt_pkg::CNT_W-1:0]    done_in;

   assign rd_arrival = rdata_ff[pwt_pkg::ENTRY_W-1 -: pwt_pkg::ARR_W];
   assign rd_burst   = rdata_ff[pwt_pkg::PRIO_W +: pwt_pkg::BURST_W];
   assign rd_prio    = rdata_ff[pwt_pkg::PRIO_W-1:0];

   assign scan_issue = cmd.scan_run && (scan_addr_ff < count_ff);
   assign raddr      = cmd.fetch ? best_ff : scan_addr_ff[pwt_pkg::IDX_W-1:0];
   assign take_best  = rd_valid_ff && !served_ff[rd_idx_ff]
                       && (!found_ff || (rd_prio < best_prio_ff));

   assign arr_ext = {{(pwt_pkg::CLOCK_W-pwt_pkg::ARR_W){1'b0}}, rd_arrival};
   assign wait_in = (clock_ff > arr_ext) ? (clock_ff - arr_ext) : '0;
   assign sum_in  = sum_ff + {{(pwt_pkg::SUM_W-pwt_pkg::CLOCK_W){1'b0}}, wait_in};
   assign done_in = done_ff + pwt_pkg::CNT_W'(1);

   assign sts.scan_done = cmd.scan_run && !rd_valid_ff && (scan_addr_ff == count_ff);
   assign sts.last_done = out_last_ff;

   // job memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < pwt_pkg::CNT_W'(pwt_pkg::MAX_JOBS))) begin
         mem_ff[count_ff[pwt_pkg::IDX_W-1:0]] <= {req_arrival, req_burst, req_prio};
      end
      rdata_ff <= mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         served_ff    <= '0;
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         clock_ff     <= '0;
         sum_ff       <= '0;
         done_ff      <= '0;
      end else begin
         if (cmd.load && (count_ff < pwt_pkg::CNT_W'(pwt_pkg::MAX_JOBS))) begin
            count_ff <= count_ff + pwt_pkg::CNT_W'(1);
         end
         if (cmd.start) begin
            clock_ff <= '0;
            sum_ff   <= '0;
            done_ff  <= '0;
         end
         if (cmd.scan_init) begin
            scan_addr_ff <= '0;
            rd_valid_ff  <= 1'b0;
            found_ff     <= 1'b0;
         end else begin
            rd_valid_ff <= scan_issue;
            if (scan_issue) begin
               scan_addr_ff <= scan_addr_ff + pwt_pkg::CNT_W'(1);
            end
            if (take_best) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            served_ff[best_ff] <= 1'b1;
            clock_ff <= clock_ff + {{(pwt_pkg::CLOCK_W-pwt_pkg::BURST_W){1'b0}}, rd_burst};
            sum_ff   <= sum_in;
            done_ff  <= done_in;
         end
         if (cmd.finish) begin
            served_ff <= '0;
            count_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr_ff[pwt_pkg::IDX_W-1:0];
      if (take_best) begin
         best_ff      <= rd_idx_ff;
         best_prio_ff <= rd_prio;
      end
      if (cmd.commit) begin
         out_index_ff   <= pwt_pkg::INDEX_W'(best_ff);
         out_arrival_ff <= rd_arrival;
         out_burst_ff   <= rd_burst;
         out_prio_ff    <= rd_prio;
         out_wait_ff    <= wait_in;
         out_sum_ff     <= sum_in;
         out_last_ff    <= (done_in == count_ff);
      end
   end

   assign rsp_job_index   = out_index_ff;
   assign rsp_job_arrival = out_arrival_ff;
   assign rsp_job_burst   = out_burst_ff;
   assign rsp_job_prio    = out_prio_ff;
   assign rsp_wait_time   = out_wait_ff;
   assign rsp_total_wait  = out_sum_ff;
   assign rsp_job_count   = pwt_pkg::COUNT_W'(count_ff);
   assign rsp_last_result = out_last_ff;

endmodule
`default_nettype wire

>>> rtl/priority_order_wait_times.sv
// top level of the non-preemptive priority scheduler
//
// jobs enter on the req_ channel, one word per job, and are stored in load order;
// up to 64 jobs are kept and any job beyond that is dropped. a word with
// req_last_job set stores its job, if there is room, and starts the run:
// all stored jobs are served in ascending priority number, ties to the
// earlier loaded job. each served job gives one rsp_ word with its wait
// time and the running total; the final word has rsp_last_result set and
// the set is then cleared. during a run req_stall stays high. each result
// takes a scan of the job memory through its single read port, then a
// read of the chosen entry, an update of the clock and running total,
// and a stay in the output register. while rsp_stall is high the result
// holds in the output register and the next scan waits. reset empties
// the job set and idles the block; job memory contents are not cleared.
`default_nettype none
module priority_order_wait_times (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pwt_pkg::ARR_W-1:0]     req_arrival,
   input  wire logic [pwt_pkg::BURST_W-1:0]   req_burst,
   input  wire logic [pwt_pkg::PRIO_W-1:0]    req_prio,
   input  wire logic                          req_last_job,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pwt_pkg::INDEX_W-1:0]        rsp_job_index,
   output logic [pwt_pkg::ARR_W-1:0]          rsp_job_arrival,
   output logic [pwt_pkg::BURST_W-1:0]        rsp_job_burst,
   output logic [pwt_pkg::PRIO_W-1:0]         rsp_job_prio,
   output logic [pwt_pkg::CLOCK_W-1:0]        rsp_wait_time,
   output logic [pwt_pkg::SUM_W-1:0]          rsp_total_wait,
   output logic [pwt_pkg::COUNT_W-1:0]        rsp_job_count,
   output logic                               rsp_last_result
);

   pwt_pkg::pwt_cmd_type cmd;
   pwt_pkg::pwt_sts_type sts;

   pwt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_job (req_last_job),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   pwt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_arrival     (req_arrival),
      .req_burst       (req_burst),
      .req_prio        (req_prio),
      .rsp_job_index   (rsp_job_index),
      .rsp_job_arrival (rsp_job_arrival),
      .rsp_job_burst   (rsp_job_burst),
      .rsp_job_prio    (rsp_job_prio),
      .rsp_wait_time   (rsp_wait_time),
      .rsp_total_wait  (rsp_total_wait),
      .rsp_job_count   (rsp_job_count),
      .rsp_last_result (rsp_last_result)
   );

   // no new job while a result is pending
   a_no_load_during_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   // after the final word the block is ready for a new set
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_result) |=> !req_stall)
      else $error("block not idle after final result");

   // running total always covers this job's wait, and the job count is not zero
   a_total_covers_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({6'd0, rsp_wait_time} <= rsp_total_wait) && (rsp_job_count != '0))
      else $error("total wait or job count inconsistent");

endmodule
`default_nettype wire

>>> tb/sv/tb_priority_order_wait_times.sv
// self-checking testbench for the non-preemptive priority scheduler
`timescale 1ns / 1ps
`default_nettype none
module tb_priority_order_wait_times;

   typedef struct {
      logic [pwt_pkg::ARR_W-1:0]   arrival;
      logic [pwt_pkg::BURST_W-1:0] burst;
      logic [pwt_pkg::PRIO_W-1:0]  prio;
      logic                        last;
   } job_word_type;

   typedef struct {
      logic [pwt_pkg::INDEX_W-1:0] index;
      logic [pwt_pkg::ARR_W-1:0]   arrival;
      logic [pwt_pkg::BURST_W-1:0] burst;
      logic [pwt_pkg::PRIO_W-1:0]  prio;
      logic [pwt_pkg::CLOCK_W-1:0] wait_time;
      logic [pwt_pkg::SUM_W-1:0]   total_wait;
      logic [pwt_pkg::COUNT_W-1:0] job_count;
      logic                        last;
   } served_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [pwt_pkg::ARR_W-1:0]     req_arrival = '0;
   logic [pwt_pkg::BURST_W-1:0]   req_burst = '0;
   logic [pwt_pkg::PRIO_W-1:0]    req_prio = '0;
   logic                          req_last_job = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [pwt_pkg::INDEX_W-1:0]   rsp_job_index;
   logic [pwt_pkg::ARR_W-1:0]     rsp_job_arrival;
   logic [pwt_pkg::BURST_W-1:0]   rsp_job_burst;
   logic [pwt_pkg::PRIO_W-1:0]    rsp_job_prio;
   logic [pwt_pkg::CLOCK_W-1:0]   rsp_wait_time;
   logic [pwt_pkg::SUM_W-1:0]     rsp_total_wait;
   logic [pwt_pkg::COUNT_W-1:0]   rsp_job_count;
   logic                          rsp_last_result;

   job_word_type                  pending_jobs[$];
   served_word_type               expected_served[$];
   job_word_type                  next_job;

   logic [pwt_pkg::ARR_W-1:0]     job_arrival_mem[pwt_pkg::MAX_JOBS];
   logic [pwt_pkg::BURST_W-1:0]   job_burst_mem[pwt_pkg::MAX_JOBS];
   logic [pwt_pkg::PRIO_W-1:0]    job_prio_mem[pwt_pkg::MAX_JOBS];
   int                            jobs_stored = 0;

   int                            jobs_planned = 0;
   int                            jobs_accepted = 0;
   int                            sets_scheduled = 0;
   int                            words_checked = 0;
   int                            mismatches = 0;
   int                            send_gap = 0;
   int                            recv_stall_left = 0;
   bit                            send_calm = 1'b0;
   bit                            recv_calm = 1'b0;
   logic                          hold_rsp = 1'b0;

   priority_order_wait_times u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_arrival     (req_arrival),
      .req_burst       (req_burst),
      .req_prio        (req_prio),
      .req_last_job    (req_last_job),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_job_index   (rsp_job_index),
      .rsp_job_arrival (rsp_job_arrival),
      .rsp_job_burst   (rsp_job_burst),
      .rsp_job_prio    (rsp_job_prio),
      .rsp_wait_time   (rsp_wait_time),
      .rsp_total_wait  (rsp_total_wait),
      .rsp_job_count   (rsp_job_count),
      .rsp_last_result (rsp_last_result)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_idle(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_job(input int arr, input int bst, input int pri, input bit last);
      job_word_type j;
      j.arrival = arr[pwt_pkg::ARR_W-1:0];
      j.burst   = bst[pwt_pkg::BURST_W-1:0];
      j.prio    = pri[pwt_pkg::PRIO_W-1:0];
      j.last    = last;
      pending_jobs.push_back(j);
   endtask

   // stores one job if there is room and, on the closing job of a set, works out the service order
   task automatic load_and_schedule(input job_word_type j);
      served_word_type               w;
      logic [pwt_pkg::MAX_JOBS-1:0]  done;
      logic [pwt_pkg::CLOCK_W-1:0]   svc_clock;
      logic [pwt_pkg::SUM_W-1:0]     wsum;
      logic [pwt_pkg::CLOCK_W-1:0]   wait_t;
      int                            n;
      int                            best;
      if (jobs_stored < pwt_pkg::MAX_JOBS) begin
         job_arrival_mem[jobs_stored] = j.arrival;
         job_burst_mem[jobs_stored]   = j.burst;
         job_prio_mem[jobs_stored]    = j.prio;
         jobs_stored++;
      end
      if (!j.last) return;
      n = jobs_stored;
      done = '0;
      svc_clock = '0;
      wsum = '0;
      sets_scheduled++;
      for (int k = 0; k < n; k++) begin
         best = -1;
         for (int i = 0; i < n; i++) begin
            if (!done[i] && (best < 0 || job_prio_mem[i] < job_prio_mem[best])) best = i;
         end
         done[best] = 1'b1;
         wait_t = (svc_clock > job_arrival_mem[best]) ?
                  svc_clock - job_arrival_mem[best] : '0;
         wsum = wsum + wait_t;
         svc_clock = svc_clock + job_burst_mem[best];
         w.index      = pwt_pkg::INDEX_W'(best);
         w.arrival    = job_arrival_mem[best];
         w.burst      = job_burst_mem[best];
         w.prio       = job_prio_mem[best];
         w.wait_time  = wait_t;
         w.total_wait = wsum;
         w.job_count  = pwt_pkg::COUNT_W'(n);
         w.last       = (k == n - 1);
         expected_served.push_back(w);
      end
      jobs_stored = 0;
   endtask

   function automatic void compare_field(string name, logic [31:0] exp_v,
                                         logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   task automatic check_served();
      served_word_type w;
      if (expected_served.size() == 0) begin
         $display("%0t: unexpected result word, expected none, actual index %0d",
                  $time, rsp_job_index);
         mismatches++;
         return;
      end
      w = expected_served.pop_front();
      words_checked++;
      compare_field("job_index", w.index, rsp_job_index);
      compare_field("job_arrival", w.arrival, rsp_job_arrival);
      compare_field("job_burst", w.burst, rsp_job_burst);
      compare_field("job_prio", w.prio, rsp_job_prio);
      compare_field("wait_time", w.wait_time, rsp_wait_time);
      compare_field("total_wait", w.total_wait, rsp_total_wait);
      compare_field("job_count", w.job_count, rsp_job_count);
      compare_field("last_result", w.last, rsp_last_result);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            load_and_schedule(next_job);
            jobs_accepted++;
         end
         if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_jobs.size() > 0) begin
               next_job = pending_jobs.pop_front();
               req_arrival  <= next_job.arrival;
               req_burst    <= next_job.burst;
               req_prio     <= next_job.prio;
               req_last_job <= next_job.last;
               req_valid    <= 1'b1;
               send_gap = pick_idle(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_served();
         if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
         end else if (recv_stall_left > 0) begin
            recv_stall_left--;
            rsp_stall <= 1'b1;
         end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
            recv_stall_left = pick_idle(1'b0);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // long receiver hold-off while the sender keeps offering words
   initial begin
      while (reset || jobs_accepted < 150) @(negedge clock);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int len;
      int arr;
      int bst;
      int pri;

      // single jobs at both extremes
      add_job(0, 0, 0, 1'b1);
      add_job(65535, 65535, 255, 1'b1);
      // ties, late arrivals clamped to zero wait, zero burst
      add_job(100, 10, 7, 1'b0);
      add_job(0, 65535, 7, 1'b0);
      add_job(65535, 1, 3, 1'b0);
      add_job(5, 0, 255, 1'b0);
      add_job(0, 20, 7, 1'b1);
      // priorities in reverse of load order, long bursts
      add_job(0, 65535, 255, 1'b0);
      add_job(0, 65535, 128, 1'b0);
      add_job(0, 65535, 1, 1'b0);
      add_job(0, 65535, 0, 1'b1);
      // all equal priority, served in load order
      for (int i = 0; i < 6; i++) add_job(i * 1000, 700 + i, 0, i == 5);
      add_job(40000, 30000, 200, 1'b0);
      add_job(1, 2, 100, 1'b1);

      // overfull set: the last two jobs are dropped, the final one still starts the run
      for (int i = 0; i < pwt_pkg::MAX_JOBS + 2; i++)
         add_job($urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 255), i == pwt_pkg::MAX_JOBS + 1);
      // exactly full set with maximum bursts
      for (int i = 0; i < pwt_pkg::MAX_JOBS; i++)
         add_job(0, 65535, $urandom_range(0, 255), i == pwt_pkg::MAX_JOBS - 1);

      while (pending_jobs.size() < 420) begin
         pri = $urandom_range(0, 99);
         len = (pri < 80) ? $urandom_range(1, 8) :
               (pri < 95) ? $urandom_range(9, 24) : $urandom_range(25, 40);
         for (int i = 0; i < len; i++) begin
            arr = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
            bst = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) :
                  $urandom_range(0, 1500);
            pri = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
            add_job(arr, bst, pri, i == len - 1);
         end
      end
      jobs_planned = pending_jobs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (jobs_accepted < jobs_planned || expected_served.size() > 0);
      repeat (300) @(posedge clock);

      $display("tb: %0d jobs in %0d sets scheduled, including an overfull and a full set",
               jobs_accepted, sets_scheduled);
      $display("tb: %0d served-job words checked, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
rtl/pwt_pkg.sv
rtl/pwt_ctrl.sv
rtl/pwt_dp.sv
rtl/priority_order_wait_times.sv
tb/sv/tb_priority_order_wait_times.sv
